>>> rtl/core/vpfr_pkg.sv
package vpfr_pkg;

    // Default assembly size of one frame half, in bytes
    localparam int unsigned FRAME_BYTES_DEF = 256 * 1024;

    // Longest isochronous packet that is accepted
    localparam int unsigned MAX_PACKET = 3072;

    // Payload header flag bits (byte 1 of a packet)
    localparam int unsigned HDR_FID_BIT = 0;
    localparam int unsigned HDR_EOF_BIT = 1;
    localparam int unsigned HDR_ERR_BIT = 6;

    // Field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PLEN_W  = 12;
    localparam int unsigned RIDX_W  = 18;
    localparam int unsigned TIME_W  = 48;
    localparam int unsigned FLEN_W  = 19;
    localparam int unsigned S_DATA_W = 88;
    localparam int unsigned M_DATA_W = 80;

    // Kind of an input transaction
    typedef enum logic [1:0] {
        ACT_PKT_BYTE = 2'd0,
        ACT_READ     = 2'd1,
        ACT_RELEASE  = 2'd2,
        ACT_RESTART  = 2'd3
    } action_t;

endpackage

>>> rtl/core/video_payload_frame_reassembler_unit.sv
// Video payload frame reassembler. Takes one transaction per clock on the s_ stream and
// returns exactly one result transaction for each on the m_ stream, through the input
// register, then the result register together with the frame store's read register.
// The rate is one transaction per clock, set by the single pass of header
// parsing and length bookkeeping between those registers; s_tready drops only while a
// result waits on m_tready. s_tuser selects the kind: packet byte, read of a held frame
// byte, release of the held frame, or stream restart. Payload bytes go to the assembly
// half of a ping-pong frame store (one single-port RAM of 2**(clog2(FRAME_BYTES)+1)
// bytes); publishing a frame flips the halves, so the held frame is read in place.
// The store needs no clearing pass after reset: only bytes already written are ever returned.
module video_payload_frame_reassembler_unit #(
    parameter int unsigned FRAME_BYTES = vpfr_pkg::FRAME_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // tdata: pkt_byte[7:0], pkt_len[19:8], read_index[37:20], time_now[85:38], zero fill
    input  logic [vpfr_pkg::S_DATA_W-1:0]  s_tdata,
    // tuser: action[1:0]
    input  logic [1:0]                     s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata: frame_ready[0], frame_length[19:1], frame_time[67:20], read_data[75:68],
    //        frame_completed[76], packet_dropped[77], zero fill
    output logic [vpfr_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready
);

    localparam int unsigned IDX_W  = $clog2(FRAME_BYTES);
    localparam int unsigned LEN_W  = $clog2(FRAME_BYTES + 1);
    localparam int unsigned ADDR_W = IDX_W + 1;
    localparam int unsigned BYTE_W = vpfr_pkg::BYTE_W;
    localparam int unsigned PLEN_W = vpfr_pkg::PLEN_W;
    localparam int unsigned RIDX_W = vpfr_pkg::RIDX_W;
    localparam int unsigned TIME_W = vpfr_pkg::TIME_W;
    localparam int unsigned FLEN_W = vpfr_pkg::FLEN_W;

    // pipeline advance
    logic adv;

    // input register
    logic                  in_valid_reg;
    vpfr_pkg::action_t     in_action_reg;
    logic [BYTE_W-1:0]     in_byte_reg;
    logic [PLEN_W-1:0]     in_len_reg;
    logic [RIDX_W-1:0]     in_ridx_reg;
    logic [TIME_W-1:0]     in_time_reg;

    // reassembly state
    logic                  side_reg, side_next;
    logic [LEN_W-1:0]      alen_reg, alen_next;
    logic                  fid_seen_reg, fid_seen_next;
    logic                  fid_reg, fid_next;
    logic                  held_reg, held_next;
    logic [LEN_W-1:0]      held_len_reg, held_len_next;
    logic [TIME_W-1:0]     held_time_reg, held_time_next;
    logic [PLEN_W-1:0]     pos_reg, pos_next;
    logic [BYTE_W-1:0]     hl_reg, hl_next;
    logic [BYTE_W-1:0]     hf_reg, hf_next;
    logic                  skip_reg, skip_next;

    // result register
    logic                  m_valid_reg;
    logic                  out_ready_reg;
    logic [FLEN_W-1:0]     out_len_reg;
    logic [TIME_W-1:0]     out_time_reg;
    logic                  out_completed_reg;
    logic                  out_dropped_reg;
    logic                  rd_hit_reg;

    // per-transaction decode
    logic                  completed;
    logic                  dropped;
    logic                  rd_hit;
    logic                  finish;
    logic                  last;
    logic [PLEN_W:0]       pos_inc;
    logic                  ram_we;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_addr;
    logic [BYTE_W-1:0]     ram_rdata;
    logic [IDX_W+RIDX_W-1:0] ridx_ext;
    logic [LEN_W+RIDX_W-1:0] ridx_cmp;
    logic [LEN_W+RIDX_W-1:0] hlen_cmp;
    logic [LEN_W+FLEN_W-1:0] hlen_out;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_tvalid;
        end
        if (adv) begin
            in_action_reg <= vpfr_pkg::action_t'(s_tuser);
            in_byte_reg   <= s_tdata[7:0];
            in_len_reg    <= s_tdata[19:8];
            in_ridx_reg   <= s_tdata[37:20];
            in_time_reg   <= s_tdata[85:38];
        end
    end

    assign pos_inc  = {1'b0, pos_reg} + {{PLEN_W{1'b0}}, 1'b1};
    assign ridx_ext = {{IDX_W{1'b0}}, in_ridx_reg};
    assign ridx_cmp = {{LEN_W{1'b0}}, in_ridx_reg};
    assign hlen_cmp = {{RIDX_W{1'b0}}, held_len_reg};

    // one pass of parsing and bookkeeping per transaction
    always_comb begin
        side_next      = side_reg;
        alen_next      = alen_reg;
        fid_seen_next  = fid_seen_reg;
        fid_next       = fid_reg;
        held_next      = held_reg;
        held_len_next  = held_len_reg;
        held_time_next = held_time_reg;
        pos_next       = pos_reg;
        hl_next        = hl_reg;
        hf_next        = hf_reg;
        skip_next      = skip_reg;
        completed      = 1'b0;
        dropped        = 1'b0;
        rd_hit         = 1'b0;
        finish         = 1'b0;
        last           = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_addr       = {side_reg, alen_reg[IDX_W-1:0]};

        if (adv && in_valid_reg) begin
            case (in_action_reg)
                vpfr_pkg::ACT_PKT_BYTE: begin
                    if (pos_reg == '0 && in_len_reg < PLEN_W'(2)) begin
                        // short packet
                        dropped = 1'b1;
                    end else begin
                        last = pos_inc >= {1'b0, in_len_reg};
                        if (pos_reg == '0) begin
                            hl_next   = in_byte_reg;
                            skip_next = 1'b0;
                        end else if (pos_reg == PLEN_W'(1)) begin
                            hf_next = in_byte_reg;
                            if (hl_reg < BYTE_W'(2)
                                || {{(PLEN_W-BYTE_W){1'b0}}, hl_reg} > in_len_reg
                                || {1'b0, in_len_reg} > (PLEN_W+1)'(vpfr_pkg::MAX_PACKET))
                            begin
                                // bad header: ignore rest of packet
                                skip_next = 1'b1;
                                dropped   = 1'b1;
                            end else if (in_byte_reg[vpfr_pkg::HDR_ERR_BIT]) begin
                                // error flag: drop packet and the partial frame
                                skip_next = 1'b1;
                                dropped   = 1'b1;
                                alen_next = '0;
                            end else begin
                                if (fid_seen_reg
                                    && in_byte_reg[vpfr_pkg::HDR_FID_BIT] != fid_reg) begin
                                    finish = 1'b1;
                                end
                                fid_seen_next = 1'b1;
                                fid_next      = in_byte_reg[vpfr_pkg::HDR_FID_BIT];
                            end
                        end else if (!skip_reg
                                     && pos_reg >= {{(PLEN_W-BYTE_W){1'b0}}, hl_reg}
                                     && alen_reg < LEN_W'(FRAME_BYTES)) begin
                            // payload byte into the assembly half
                            ram_we    = 1'b1;
                            alen_next = alen_reg + LEN_W'(1);
                        end
                        if (last && pos_reg != '0 && !skip_next
                            && hf_next[vpfr_pkg::HDR_EOF_BIT]) begin
                            finish = 1'b1;
                        end
                        pos_next = last ? '0 : pos_inc[PLEN_W-1:0];
                    end
                end
                vpfr_pkg::ACT_READ: begin
                    ram_re   = 1'b1;
                    ram_addr = {~side_reg, ridx_ext[IDX_W-1:0]};
                    rd_hit   = held_reg && (ridx_cmp < hlen_cmp);
                end
                vpfr_pkg::ACT_RELEASE: begin
                    held_next = 1'b0;
                end
                vpfr_pkg::ACT_RESTART: begin
                    alen_next     = '0;
                    fid_seen_next = 1'b0;
                    held_next     = 1'b0;
                    pos_next      = '0;
                    skip_next     = 1'b0;
                end
                default: begin
                end
            endcase

            // publish a non-empty assembly by swapping halves when nothing is held
            if (finish) begin
                if (alen_next != '0 && !held_reg) begin
                    held_len_next  = alen_next;
                    held_time_next = in_time_reg;
                    held_next      = 1'b1;
                    side_next      = ~side_reg;
                    completed      = 1'b1;
                end
                alen_next = '0;
            end
        end
    end

    assign hlen_out = {{FLEN_W{1'b0}}, held_len_next};

    // state and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg      <= 1'b0;
            alen_reg      <= '0;
            fid_seen_reg  <= 1'b0;
            fid_reg       <= 1'b0;
            held_reg      <= 1'b0;
            held_len_reg  <= '0;
            held_time_reg <= '0;
            pos_reg       <= '0;
            hl_reg        <= '0;
            hf_reg        <= '0;
            skip_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            side_reg      <= side_next;
            alen_reg      <= alen_next;
            fid_seen_reg  <= fid_seen_next;
            fid_reg       <= fid_next;
            held_reg      <= held_next;
            held_len_reg  <= held_len_next;
            held_time_reg <= held_time_next;
            pos_reg       <= pos_next;
            hl_reg        <= hl_next;
            hf_reg        <= hf_next;
            skip_reg      <= skip_next;
            if (adv) begin
                m_valid_reg <= in_valid_reg;
            end
        end
        if (adv) begin
            out_ready_reg     <= held_next;
            out_len_reg       <= held_next ? hlen_out[FLEN_W-1:0] : '0;
            out_time_reg      <= held_next ? held_time_next : '0;
            out_completed_reg <= completed;
            out_dropped_reg   <= dropped;
            rd_hit_reg        <= rd_hit;
        end
    end

    vpfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (1 << ADDR_W)
    ) u_frame_store (
        .clk   (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (in_byte_reg),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00,
                       out_dropped_reg,
                       out_completed_reg,
                       (rd_hit_reg ? ram_rdata : {BYTE_W{1'b0}}),
                       out_time_reg,
                       out_len_reg,
                       out_ready_reg};

    // a transaction never both publishes and drops
    a_done_xor_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(out_completed_reg && out_dropped_reg))
        else $error("frame published and packet dropped in one transaction");

    // a published frame is held in the same result
    a_done_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_completed_reg) |-> out_ready_reg)
        else $error("published frame not reported as held");

    // halves swap only together with a publish
    a_swap_publish: assert property (@(posedge aclk) disable iff (!aresetn)
        (side_reg != $past(side_reg)) |-> (out_completed_reg && held_reg))
        else $error("frame store halves swapped without a publish");

    // assembly never grows past one half
    a_alen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        alen_reg <= LEN_W'(FRAME_BYTES))
        else $error("assembly length beyond frame size");

    // a read hit needs a held frame at the time of the read
    a_hit_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && rd_hit) |=> (rd_hit_reg && $past(held_reg)))
        else $error("read hit without a held frame");

endmodule

>>> rtl/core/vpfr_ram.sv
module vpfr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single port, registered read that holds while re is low
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sim/frame_reassembly_checker.sv
`timescale 1ns / 1ps

// Watches both streams, predicts the status of every input transaction and
// compares it with the result transactions in order.
module frame_reassembly_checker #(
    parameter int unsigned FRAME_BYTES = vpfr_pkg::FRAME_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // tdata: pkt_byte[7:0], pkt_len[19:8], read_index[37:20], time_now[85:38], zero fill
    input  logic [vpfr_pkg::S_DATA_W-1:0] s_tdata,
    // tuser: action[1:0]
    input  logic [1:0]                    s_tuser,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // tdata: frame_ready[0], frame_length[19:1], frame_time[67:20], read_data[75:68],
    //        frame_completed[76], packet_dropped[77], zero fill
    input  logic [vpfr_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    output int unsigned                   failures,
    output int unsigned                   pending_results,
    output int unsigned                   results_checked,
    output int unsigned                   frames_published,
    output int unsigned                   packets_dropped
);

    localparam logic [1:0]  FID_NONE     = 2'd2;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct packed {
        logic                        frame_ready;
        logic [vpfr_pkg::FLEN_W-1:0] frame_length;
        logic [vpfr_pkg::TIME_W-1:0] frame_time;
        logic [vpfr_pkg::BYTE_W-1:0] read_data;
        logic                        frame_completed;
        logic                        packet_dropped;
    } frame_status_t;

    // Mirror of the reassembler state
    logic [7:0]  frame_mem [0:2*FRAME_BYTES-1];
    logic        asm_side  = 1'b0;
    int unsigned asm_len   = 0;
    logic [1:0]  last_fid  = FID_NONE;
    logic        held      = 1'b0;
    int unsigned held_len  = 0;
    logic [47:0] held_ts   = '0;
    int unsigned byte_pos  = 0;
    logic [7:0]  hdr_len   = '0;
    logic [7:0]  hdr_flags = '0;
    logic        pkt_skip  = 1'b0;

    frame_status_t status_due [$];
    frame_status_t want;
    frame_status_t got;
    int unsigned   fail_cnt      = 0;
    int unsigned   checked_cnt   = 0;
    int unsigned   published_cnt = 0;
    int unsigned   dropped_cnt   = 0;

    // Hand the assembly over as the held frame if possible; it restarts empty either way
    function automatic logic publish_frame(input logic [47:0] now);
        logic done;
        done = 1'b0;
        if (asm_len != 0 && !held) begin
            held_len = asm_len;
            held_ts  = now;
            held     = 1'b1;
            asm_side = ~asm_side;
            done     = 1'b1;
        end
        asm_len = 0;
        return done;
    endfunction

    function automatic frame_status_t predict_status(input vpfr_pkg::action_t act,
                                                     input logic [7:0] b,
                                                     input logic [11:0] len,
                                                     input logic [17:0] ridx,
                                                     input logic [47:0] now);
        frame_status_t r;
        int unsigned   p;
        logic          pkt_end;
        r = '0;
        case (act)
            vpfr_pkg::ACT_PKT_BYTE: begin
                p = byte_pos;
                if (p == 0 && len < 2) begin
                    // too short to carry a header: dropped, parsing stays at byte 0
                    r.packet_dropped = 1'b1;
                end else begin
                    pkt_end = (p + 1 >= len);
                    if (p == 0) begin
                        hdr_len  = b;
                        pkt_skip = 1'b0;
                    end else if (p == 1) begin
                        hdr_flags = b;
                        if (hdr_len < 2 || hdr_len > len || len > vpfr_pkg::MAX_PACKET) begin
                            pkt_skip         = 1'b1;
                            r.packet_dropped = 1'b1;
                        end else if (b[vpfr_pkg::HDR_ERR_BIT]) begin
                            pkt_skip         = 1'b1;
                            r.packet_dropped = 1'b1;
                            asm_len          = 0;
                        end else begin
                            // frame id toggle closes the frame under assembly
                            if (last_fid != FID_NONE
                                    && {1'b0, b[vpfr_pkg::HDR_FID_BIT]} != last_fid)
                                r.frame_completed = publish_frame(now);
                            last_fid = {1'b0, b[vpfr_pkg::HDR_FID_BIT]};
                        end
                    end else if (!pkt_skip && p >= hdr_len) begin
                        // payload, saturating at the size of one half
                        if (asm_len < FRAME_BYTES) begin
                            frame_mem[asm_side ? FRAME_BYTES + asm_len : asm_len] = b;
                            asm_len++;
                        end
                    end
                    if (pkt_end && p >= 1 && !pkt_skip
                            && hdr_flags[vpfr_pkg::HDR_EOF_BIT]) begin
                        if (publish_frame(now))
                            r.frame_completed = 1'b1;
                    end
                    byte_pos = pkt_end ? 0 : ((p + 1) & 32'hFFF);
                end
            end
            vpfr_pkg::ACT_READ: begin
                if (held && ridx < held_len)
                    r.read_data = frame_mem[asm_side ? ridx : FRAME_BYTES + ridx];
            end
            vpfr_pkg::ACT_RELEASE: begin
                held = 1'b0;
            end
            default: begin
                asm_len  = 0;
                last_fid = FID_NONE;
                held     = 1'b0;
                byte_pos = 0;
                pkt_skip = 1'b0;
            end
        endcase
        r.frame_ready  = held;
        r.frame_length = held ? held_len[vpfr_pkg::FLEN_W-1:0] : '0;
        r.frame_time   = held ? held_ts : '0;
        return r;
    endfunction

    // Result transactions are compared before the input of the same edge is predicted
    always @(posedge aclk) begin
        if (!aresetn) begin
            asm_side  = 1'b0;
            asm_len   = 0;
            last_fid  = FID_NONE;
            held      = 1'b0;
            held_len  = 0;
            held_ts   = '0;
            byte_pos  = 0;
            hdr_len   = '0;
            hdr_flags = '0;
            pkt_skip  = 1'b0;
            status_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.frame_ready     = m_tdata[0];
                got.frame_length    = m_tdata[19:1];
                got.frame_time      = m_tdata[67:20];
                got.read_data       = m_tdata[75:68];
                got.frame_completed = m_tdata[76];
                got.packet_dropped  = m_tdata[77];
                if (status_due.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_LIMIT)
                        $display("%0t: result transaction with none expected: %h",
                                 $time, m_tdata);
                end else begin
                    want = status_due.pop_front();
                    checked_cnt++;
                    if (got.frame_ready !== want.frame_ready
                            || got.frame_length !== want.frame_length
                            || got.frame_time !== want.frame_time
                            || got.read_data !== want.read_data
                            || got.frame_completed !== want.frame_completed
                            || got.packet_dropped !== want.packet_dropped) begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_LIMIT) begin
                            $display("%0t: mismatch on result %0d", $time, checked_cnt);
                            $display({"  expected ready=%0b len=%0d time=%h data=%h",
                                      " done=%0b drop=%0b"},
                                     want.frame_ready, want.frame_length, want.frame_time,
                                     want.read_data, want.frame_completed,
                                     want.packet_dropped);
                            $display({"  actual   ready=%0b len=%0d time=%h data=%h",
                                      " done=%0b drop=%0b"},
                                     got.frame_ready, got.frame_length, got.frame_time,
                                     got.read_data, got.frame_completed, got.packet_dropped);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                want = predict_status(vpfr_pkg::action_t'(s_tuser), s_tdata[7:0],
                                      s_tdata[19:8], s_tdata[37:20], s_tdata[85:38]);
                if (want.frame_completed)
                    published_cnt++;
                if (want.packet_dropped)
                    dropped_cnt++;
                status_due.push_back(want);
            end
        end
        failures         <= fail_cnt;
        pending_results  <= int'(unsigned'(status_due.size()));
        results_checked  <= checked_cnt;
        frames_published <= published_cnt;
        packets_dropped  <= dropped_cnt;
    end

endmodule

>>> sim/video_payload_frame_reassembler_unit_test.sv
`timescale 1ns / 1ps

module video_payload_frame_reassembler_unit_test;

    // A frame half of 1024 bytes keeps the store small in simulation
    localparam int unsigned SIM_FRAME_BYTES = 1024;
    localparam int unsigned RANDOM_ITEMS    = 375;
    localparam int unsigned DRAIN_LIMIT     = 20000;
    localparam int unsigned FLAG_FID        = 1 << vpfr_pkg::HDR_FID_BIT;
    localparam int unsigned FLAG_EOF        = 1 << vpfr_pkg::HDR_EOF_BIT;
    localparam int unsigned FLAG_ERR        = 1 << vpfr_pkg::HDR_ERR_BIT;
    localparam int unsigned PLAIN_FLAGS     = 255 & ~(FLAG_FID | FLAG_EOF | FLAG_ERR);

    typedef enum logic [1:0] {RX_STEADY, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_mode_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic [vpfr_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic [1:0]                    s_tuser  = vpfr_pkg::ACT_PKT_BYTE;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [vpfr_pkg::M_DATA_W-1:0] m_tdata;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;

    int unsigned failures;
    int unsigned pending_results;
    int unsigned results_checked;
    int unsigned frames_published;
    int unsigned packets_dropped;

    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    rx_mode_t    rx_mode    = RX_STEADY;
    logic [7:0]  mode_left  = 8'd0;

    video_payload_frame_reassembler_unit #(
        .FRAME_BYTES(SIM_FRAME_BYTES)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    frame_reassembly_checker #(
        .FRAME_BYTES(SIM_FRAME_BYTES)
    ) reassembly_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .m_tdata         (m_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .failures        (failures),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .frames_published(frames_published),
        .packets_dropped (packets_dropped)
    );

    always #5 aclk = ~aclk;

    // Result side: stall pattern switches between steady, light, periodic and heavy modes
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            rx_mode   <= rx_mode_t'($urandom_range(0, 3));
            mode_left <= 8'($urandom_range(16, 200));
        end else begin
            mode_left <= mode_left - 8'd1;
        end
        case (rx_mode)
            RX_STEADY:   m_tready <= 1'b1;
            RX_LIGHT:    m_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: m_tready <= (mode_left[2:0] != 0);
            default:     m_tready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    function automatic logic [47:0] rand_time();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    // One input transaction; bursts of random length, mostly separated by idle gaps
    task automatic send_item(input vpfr_pkg::action_t act, input int unsigned b,
                             input int unsigned len, input int unsigned ridx,
                             input logic [47:0] ts);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {2'b00, ts, ridx[17:0], len[11:0], b[7:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // Packet of n bytes: header length, flags, then random bytes. Non-final bytes carry
    // tag_len; the final one carries n, or a random length that still ends the packet.
    task automatic send_packet(input int unsigned hdr, input int unsigned flags,
                               input int unsigned tag_len, input int unsigned n,
                               input bit trim);
        int unsigned b;
        int unsigned len;
        for (int unsigned pos = 0; pos < n; pos++) begin
            b = (pos == 0) ? hdr : (pos == 1) ? flags : $urandom_range(0, 255);
            if (pos != n - 1)
                len = tag_len;
            else
                len = trim ? $urandom_range(0, n) : n;
            send_item(vpfr_pkg::ACT_PKT_BYTE, b, len, 0, rand_time());
        end
    endtask

    // Consumer side: a few reads, mostly inside small frames, then maybe a release
    task automatic serve_consumer(input int unsigned reads, input bit let_go);
        int unsigned idx;
        repeat (reads) begin
            idx = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 262143)
                                              : $urandom_range(0, 31);
            send_item(vpfr_pkg::ACT_READ, $urandom_range(0, 255), 0, idx, rand_time());
        end
        if (let_go)
            send_item(vpfr_pkg::ACT_RELEASE, $urandom_range(0, 255), 0, 0, rand_time());
    endtask

    initial begin
        int unsigned random_start;
        int unsigned pick;
        int unsigned npkts;
        int unsigned n;
        int unsigned hdr;
        int unsigned flags;
        int unsigned frame_id;
        int unsigned guard;
        bit          close_eof;

        frame_id = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Nothing held yet: read at the top index and release
        send_item(vpfr_pkg::ACT_READ, 0, 0, 262143, rand_time());
        send_item(vpfr_pkg::ACT_RELEASE, 0, 0, 0, rand_time());
        // Short packets, lengths zero and one
        send_item(vpfr_pkg::ACT_PKT_BYTE, 255, 0, 0, rand_time());
        send_item(vpfr_pkg::ACT_PKT_BYTE, 2, 1, 0, rand_time());
        // First frame id seen: two payload bytes at the byte extremes
        send_item(vpfr_pkg::ACT_PKT_BYTE, 2, 4, 0, rand_time());
        send_item(vpfr_pkg::ACT_PKT_BYTE, 0, 4, 0, rand_time());
        send_item(vpfr_pkg::ACT_PKT_BYTE, 255, 4, 0, rand_time());
        send_item(vpfr_pkg::ACT_PKT_BYTE, 0, 4, 0, rand_time());
        // Id toggle publishes at the largest time; end of frame then finds a frame held
        send_item(vpfr_pkg::ACT_PKT_BYTE, 3, 5, 0, rand_time());
        send_item(vpfr_pkg::ACT_PKT_BYTE, FLAG_FID | FLAG_EOF, 5, 0, 48'hFFFF_FFFF_FFFF);
        send_item(vpfr_pkg::ACT_PKT_BYTE, 8'h80, 5, 0, rand_time());
        send_item(vpfr_pkg::ACT_PKT_BYTE, 8'hAA, 5, 0, rand_time());
        send_item(vpfr_pkg::ACT_PKT_BYTE, 8'h55, 5, 0, rand_time());
        // Read back in range, then one past the end
        send_item(vpfr_pkg::ACT_READ, 0, 0, 0, rand_time());
        send_item(vpfr_pkg::ACT_READ, 0, 0, 1, rand_time());
        send_item(vpfr_pkg::ACT_READ, 0, 0, 2, rand_time());
        // Header length too small, packet length above the maximum, error flag
        send_packet(1, FLAG_EOF, 3, 3, 1'b0);
        send_packet(2, 0, 4000, 3, 1'b0);
        send_packet(2, FLAG_ERR, 2, 2, 1'b0);
        send_item(vpfr_pkg::ACT_RESTART, 0, 0, 0, rand_time());

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // Well-formed frame: packets share an id, closed by end flag or next toggle
                frame_id ^= 1;
                npkts     = $urandom_range(1, 3);
                close_eof = $urandom_range(0, 1);
                for (int unsigned k = 0; k < npkts; k++) begin
                    n = ($urandom_range(0, 29) == 0) ? $urandom_range(25, 120)
                                                     : $urandom_range(2, 12);
                    hdr   = ($urandom_range(0, 4) == 0) ? $urandom_range(2, n) : 2;
                    flags = ($urandom_range(0, 255) & PLAIN_FLAGS) | frame_id;
                    if (close_eof && k == npkts - 1)
                        flags |= FLAG_EOF;
                    send_packet(hdr, flags, n, n, $urandom_range(0, 7) == 0);
                    if ($urandom_range(0, 6) == 0)
                        serve_consumer(1, 1'b0);
                end
                serve_consumer($urandom_range(0, 3), $urandom_range(0, 1));
            end else if (pick < 72) begin
                // Broken packets
                n     = $urandom_range(2, 8);
                flags = ($urandom_range(0, 255) & PLAIN_FLAGS) | frame_id;
                case ($urandom_range(0, 4))
                    0: send_packet($urandom_range(0, 1), flags, n, n, 1'b0);
                    1: send_packet($urandom_range(n + 1, 255), flags, n, n, 1'b0);
                    2: send_packet(2, flags, $urandom_range(vpfr_pkg::MAX_PACKET + 1, 4095),
                                   $urandom_range(3, 6), 1'b0);
                    3: send_packet(2, flags | FLAG_ERR | ($urandom_range(0, 1) * FLAG_EOF),
                                   n, n, 1'b0);
                    default: send_item(vpfr_pkg::ACT_PKT_BYTE, $urandom_range(0, 255),
                                       $urandom_range(0, 1), 0, rand_time());
                endcase
            end else if (pick < 82) begin
                serve_consumer($urandom_range(1, 3), $urandom_range(0, 1));
            end else if (pick < 96) begin
                // Noise: fully random transactions
                repeat ($urandom_range(1, 4))
                    send_item(vpfr_pkg::action_t'($urandom_range(0, 3)),
                              $urandom_range(0, 255), $urandom_range(0, 4095),
                              $urandom_range(0, 262143), rand_time());
            end else begin
                send_item(vpfr_pkg::ACT_RESTART, $urandom_range(0, 255), 0, 0, rand_time());
            end
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then allow for the pipeline depth
        guard = 0;
        @(posedge aclk);
        while (pending_results != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (8) @(posedge aclk);

        $display("Run covered %0d input transactions (%0d random), %0d results checked,",
                 items_sent, items_sent - random_start, results_checked);
        $display("with %0d frames published and %0d packets rejected.",
                 frames_published, packets_dropped);
        if (failures == 0 && pending_results == 0) begin
            $display("video_payload_frame_reassembler_unit_test: PASS");
        end else begin
            $display("%0d mismatches, %0d results never arrived", failures, pending_results);
            $display("video_payload_frame_reassembler_unit_test: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Timed out with %0d results outstanding", pending_results);
        $display("video_payload_frame_reassembler_unit_test: FAIL");
        $finish;
    end

endmodule
